### hdl/mtw_pkg.sv
`default_nettype none

package mtw_pkg;

  localparam int unsigned MT_WORDS = 624;
  localparam int unsigned MT_SHIFT = 397;
  localparam int unsigned CNT_W    = $clog2(MT_WORDS);

  localparam logic [31:0] MT_MATRIX       = 32'h9908_b0df;
  localparam logic [31:0] MT_UPPER        = 32'h8000_0000;
  localparam logic [31:0] MT_LOWER        = 32'h7fff_ffff;
  localparam logic [31:0] MT_INIT_MULT    = 32'd1812433253;
  localparam logic [31:0] MT_SEED_DEFAULT = 32'd5489;
  localparam logic [31:0] MT_TEMPER_B     = 32'h9d2c_5680;
  localparam logic [31:0] MT_TEMPER_C     = 32'hefc6_0000;

  localparam logic REG_SEED = 1'b0;

  typedef struct packed {
    logic [31:0] head;
    logic [31:0] next;
    logic [31:0] far;
    logic [31:0] tail;
  } mtw_taps_t;

  function automatic logic [31:0] mtw_twist(input mtw_taps_t taps);
    logic [31:0] h;
    logic [31:0] mix;
    h   = (taps.head & MT_UPPER) | (taps.next & MT_LOWER);
    mix = h[0] ? MT_MATRIX : 32'd0;
    return taps.far ^ (h >> 1) ^ mix;
  endfunction

  function automatic logic [31:0] mtw_seed_next(input logic [31:0] prev,
                                                input logic [CNT_W-1:0] k);
    logic [31:0] x;
    logic [31:0] prod;
    x    = prev ^ (prev >> 30);
    prod = 32'(MT_INIT_MULT * x);
    return prod + 32'(k);
  endfunction

  function automatic logic [31:0] mtw_temper(input logic [31:0] w);
    logic [31:0] e;
    e = w;
    e = e ^ (e >> 11);
    e = e ^ ((e << 7) & MT_TEMPER_B);
    e = e ^ ((e << 15) & MT_TEMPER_C);
    e = e ^ (e >> 18);
    return e;
  endfunction

endpackage

`default_nettype wire

### hdl/mtw_draw_if.sv
`default_nettype none

interface mtw_draw_if;
  logic valid;
  logic ready;
  logic draw;

  modport source (output valid, output draw, input ready);
  modport sink (input valid, input draw, output ready);
endinterface

`default_nettype wire

### hdl/mtw_word_if.sv
`default_nettype none

interface mtw_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink (input valid, input random_word, output ready);
endinterface

`default_nettype wire

### hdl/mt19937_random_word_generator_unit.sv
// Channel   | Dir | Payload            | Handshake
// draw_in   | in  | draw (1 bit)       | valid/ready, taken when both high
// word_out  | out | random_word (32)   | valid/ready, taken when both high
// APB       | in  | seed at byte 0     | write on psel & penable & pwrite
//
// The first draw after reset seeds the 624-cell chain, one cell per cycle,
// and its word is formed once seeding ends; no request is taken meanwhile.
// Then one word per cycle unless the output stalls: each draw shifts the chain
// once, with the new word formed from cells 0, 1 and 397. Reset clears control
// and restores the default seed; the chain itself is filled by seeding. A stalled
// output holds its word and stalls the input; a draw of 0 is taken with no result.
`default_nettype none

module mt19937_random_word_generator_unit
  import mtw_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  mtw_draw_if.sink         draw_in,
  mtw_word_if.source       word_out,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  typedef enum logic [1:0] {
    ST_UNSEEDED,
    ST_SEEDING,
    ST_FIRST,
    ST_RUN
  } state_e;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MT_WORDS - 1);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic [31:0]      out_word_q, out_word_d;
  logic [31:0]      seed_q;

  mtw_taps_t   taps;
  logic [31:0] tail_d;
  logic        shift;
  logic        in_acc;
  logic        load_out;

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SEED) ? seed_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= MT_SEED_DEFAULT;
    end else if (psel && penable && pwrite && (paddr[2] == REG_SEED)) begin
      seed_q <= pwdata;
    end
  end

  // handshake
  assign draw_in.ready = (state_q == ST_UNSEEDED) ||
                         ((state_q == ST_RUN) && (!out_valid_q || word_out.ready));
  assign in_acc = draw_in.valid && draw_in.ready;

  assign load_out = (state_q == ST_FIRST) ||
                    ((state_q == ST_RUN) && in_acc && draw_in.draw);
  assign shift    = (state_q == ST_SEEDING) || load_out;

  always_comb begin
    if (state_q == ST_SEEDING) begin
      tail_d = (cnt_q == '0) ? seed_q : mtw_seed_next(taps.tail, cnt_q);
    end else begin
      tail_d = mtw_twist(taps);
    end
  end

  mtw_chain u_chain (
    .clk_i    (clk_i),
    .shift_i  (shift),
    .tail_d_i (tail_d),
    .taps_o   (taps)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    if (word_out.ready) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
      out_word_d  = mtw_temper(tail_d);
    end
    case (state_q)
      ST_UNSEEDED: begin
        if (in_acc && draw_in.draw) begin
          state_d = ST_SEEDING;
          cnt_d   = '0;
        end
      end
      ST_SEEDING: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          state_d = ST_FIRST;
        end
      end
      ST_FIRST: begin
        state_d = ST_RUN;
      end
      ST_RUN: begin
        state_d = ST_RUN;
      end
      default: begin
        state_d = ST_UNSEEDED;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_UNSEEDED;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      out_word_q  <= out_word_d;
    end
  end

  assign word_out.valid       = out_valid_q;
  assign word_out.random_word = out_word_q;

  a_no_req_while_seeding: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEEDING) |-> !draw_in.ready)
    else $error("request taken while seeding");

  a_seed_full_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEEDING && state_d == ST_FIRST) |-> (cnt_q == CNT_LAST))
    else $error("seeding left early");

  a_first_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIRST) |-> !out_valid_q)
    else $error("output busy when first word is formed");

  a_out_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(load_out))
    else $error("result without a draw");

  a_no_out_before_seed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UNSEEDED || state_q == ST_SEEDING) |-> !out_valid_q)
    else $error("result before seeding done");

endmodule

`default_nettype wire

### hdl/mtw_cell.sv
`default_nettype none

module mtw_cell (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [31:0] d_i,
  output logic [31:0]      q_o
);

  logic [31:0] word_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= d_i;
    end
  end

  assign q_o = word_q;

endmodule

`default_nettype wire

### hdl/mtw_chain.sv
`default_nettype none

module mtw_chain
  import mtw_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        shift_i,
  input  wire logic [31:0] tail_d_i,
  output mtw_taps_t        taps_o
);

  logic [31:0] word [MT_WORDS];

  for (genvar i = 0; i < int'(MT_WORDS); i++) begin : g_cell
    logic [31:0] cell_d;
    if (i == int'(MT_WORDS) - 1) begin : g_tail
      assign cell_d = tail_d_i;
    end else begin : g_body
      assign cell_d = word[i+1];
    end
    mtw_cell u_cell (
      .clk_i (clk_i),
      .en_i  (shift_i),
      .d_i   (cell_d),
      .q_o   (word[i])
    );
  end

  assign taps_o.head = word[0];
  assign taps_o.next = word[1];
  assign taps_o.far  = word[MT_SHIFT];
  assign taps_o.tail = word[MT_WORDS-1];

endmodule

`default_nettype wire
